// ===== sv/tmpc_pkg.sv =====
// ----------------------------------------------------------------------------
// tmpc_pkg: shared types and constants for the two-motor press counter
// Widths, reset values, register indexes and lane-to-lane control structs.
// ----------------------------------------------------------------------------
package tmpc_pkg;

	localparam int BUTTON_COUNT = 4;
	localparam int MOTOR_COUNT  = 2;
	localparam int TIMER_W_DEF  = 32;

	localparam int STEP_W  = 20;
	localparam int GAP_W   = 16;
	localparam int CNT_W   = 16;
	localparam int PRESS_W = 8;
	localparam int CFG_W   = 20;
	localparam int IDX_W   = 3;

	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 24;

	localparam logic [GAP_W-1:0] WINDOW_RST  = 16'd3000;
	localparam logic [GAP_W-1:0] MIN_GAP_RST = 16'd200;
	localparam logic [GAP_W-1:0] MAX_GAP_RST = 16'd600;

	typedef enum logic [IDX_W-1:0] {
		REG_M1_STEP = 3'd0,
		REG_M2_STEP = 3'd1,
		REG_WINDOW  = 3'd2,
		REG_MIN_GAP = 3'd3,
		REG_MAX_GAP = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_STOP = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// motor lane -> button lane
	typedef struct packed {
		logic halt;    // motor stopped this tick: clear tally
		logic enable;  // button is serviced this tick
	} btn_ctl_t;

	// button lane -> motor lane
	typedef struct packed {
		logic               release_hit; // window closed on release
		logic [PRESS_W-1:0] tally;       // tally at release
	} btn_evt_t;

endpackage

// ===== sv/two_motor_press_count_travel.sv =====
// ----------------------------------------------------------------------------
// two_motor_press_count_travel: press counter and timed travel for two motors
// One input beat per millisecond tick; one result beat per tick.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake         payload
//  s_*       in   tvalid/tready     tick: buttons, limits, emergency stop bits
//  m_*       out  tvalid/tready     drive bits and both press counts
//  cfg_*     in   cfg_we            register index + data, write only
//
//  One tick per clock while s_tready is high: the whole tick update (timer
//  aging, stop check, button service, start) runs in the cycle the beat is
//  taken, in four button lanes and two motor lanes, so a new tick may follow
//  every cycle. The result is registered in the output register, or in the
//  skid beat while m_tready is low; once the skid beat is full, s_tready drops.
//  The travel budget step*presses is registered per motor ahead of use.
//  arst_n clears all state but the merge data registers and loads the register defaults.
//
// ----------------------------------------------------------------------------
module two_motor_press_count_travel
	import tmpc_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_W_DEF  // run timer width, 16..32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// tick in: [3:0] button_pressed, [7:4] limit_reached, [9:8] estop_bits
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// result out: [3:0] drive_bits, [11:4] motor1_presses, [19:12] motor2_presses
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	// register writes
	input  logic                  cfg_we,
	input  logic [IDX_W-1:0]      cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	logic [STEP_W-1:0] m1_step_q, m2_step_q;
	logic [STEP_W-1:0] m1_step_nxt, m2_step_nxt;
	logic [GAP_W-1:0]  window_q, min_gap_q, max_gap_q;

	logic                    accept;
	logic [3:0]              buttons, limits;
	logic [1:0]              force_bits;
	btn_ctl_t                ctl [BUTTON_COUNT];
	btn_evt_t                evt [BUTTON_COUNT];
	dir_t                    dir_n [MOTOR_COUNT];
	logic [PRESS_W-1:0]      presses_n [MOTOR_COUNT];

	assign accept     = s_tvalid && s_tready;
	assign buttons    = s_tdata[3:0];
	assign limits     = s_tdata[7:4];
	assign force_bits = s_tdata[9:8];

	// Registers. Step values feed the budget multiply in the write cycle too,
	// so the product is already current when the next tick arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m1_step_q <= '0;
			m2_step_q <= '0;
			window_q  <= WINDOW_RST;
			min_gap_q <= MIN_GAP_RST;
			max_gap_q <= MAX_GAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_M1_STEP: m1_step_q <= cfg_data;
				REG_M2_STEP: m2_step_q <= cfg_data;
				REG_WINDOW:  window_q  <= cfg_data[GAP_W-1:0];
				REG_MIN_GAP: min_gap_q <= cfg_data[GAP_W-1:0];
				REG_MAX_GAP: max_gap_q <= cfg_data[GAP_W-1:0];
				default:     ;  // unmapped index, dropped
			endcase
		end
	end

	assign m1_step_nxt = (cfg_we && cfg_index == REG_M1_STEP) ? cfg_data : m1_step_q;
	assign m2_step_nxt = (cfg_we && cfg_index == REG_M2_STEP) ? cfg_data : m2_step_q;

	// Button lanes: up1, down1, up2, down2.
	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_btn
		tmpc_btn_lane u_btn (
			.clk        (clk),
			.arst_n     (arst_n),
			.accept     (accept),
			.btn        (buttons[b]),
			.ctl        (ctl[b]),
			.window_ms  (window_q),
			.min_gap_ms (min_gap_q),
			.max_gap_ms (max_gap_q),
			.evt        (evt[b])
		);
	end

	// Motor lanes; each owns the two buttons and limits of its motor.
	tmpc_motor_lane #(.TIMER_WIDTH(TIMER_WIDTH)) u_motor1 (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.limit      (limits[1:0]),
		.estop      (force_bits[0]),
		.step_nxt   (m1_step_nxt),
		.evt        (evt[0:1]),
		.ctl        (ctl[0:1]),
		.dir_n      (dir_n[0]),
		.presses_n  (presses_n[0])
	);

	tmpc_motor_lane #(.TIMER_WIDTH(TIMER_WIDTH)) u_motor2 (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.limit      (limits[3:2]),
		.estop      (force_bits[1]),
		.step_nxt   (m2_step_nxt),
		.evt        (evt[2:3]),
		.ctl        (ctl[2:3]),
		.dir_n      (dir_n[1]),
		.presses_n  (presses_n[1])
	);

	// Merge: build the result beat and hold it for the downstream side.
	tmpc_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.dir1     (dir_n[0]),
		.dir2     (dir_n[1]),
		.presses1 (presses_n[0]),
		.presses2 (presses_n[1]),
		.in_ready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== sv/tmpc_btn_lane.sv =====
// ----------------------------------------------------------------------------
// tmpc_btn_lane: one button's press counting window
// Runs the window and gap timers, counts presses, reports a release.
// ----------------------------------------------------------------------------
module tmpc_btn_lane
	import tmpc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic             btn,
	input  btn_ctl_t         ctl,
	input  logic [GAP_W-1:0] window_ms,
	input  logic [GAP_W-1:0] min_gap_ms,
	input  logic [GAP_W-1:0] max_gap_ms,
	output btn_evt_t         evt
);

	logic               counting_q;
	logic [CNT_W-1:0]   win_q, since_q;
	logic [PRESS_W-1:0] tally_q;

	logic [CNT_W-1:0]   win_i, since_i;
	logic [PRESS_W-1:0] tally_h;
	logic               c_n;
	logic [CNT_W-1:0]   w_n, s_n;
	logic [PRESS_W-1:0] t_n;
	logic               ok;

	always_comb begin
		win_i   = (counting_q && win_q != '1) ? win_q + 1'b1 : win_q;
		since_i = (counting_q && since_q != '1) ? since_q + 1'b1 : since_q;
		tally_h = ctl.halt ? '0 : tally_q;

		c_n = counting_q;
		w_n = win_i;
		s_n = since_i;
		t_n = tally_h;
		ok  = 1'b0;
		evt.release_hit = 1'b0;
		evt.tally       = tally_h;

		if (btn) begin
			if (!counting_q) begin
				c_n = 1'b1;
				w_n = '0;
				s_n = '0;
				t_n = '0;
			end
			if (w_n <= window_ms) begin
				ok = (t_n == '0) || (s_n > min_gap_ms && s_n < max_gap_ms);
				if (ok) begin
					t_n = (t_n == '1) ? t_n : t_n + 1'b1;
					s_n = '0;
				end
			end
		end else if (counting_q && win_i > window_ms) begin
			c_n = 1'b0;
			t_n = '0;
			evt.release_hit = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counting_q <= 1'b0;
			win_q      <= '0;
			since_q    <= '0;
			tally_q    <= '0;
		end else if (accept) begin
			// a skipped button still ages and still loses its tally on a halt
			counting_q <= ctl.enable ? c_n : counting_q;
			win_q      <= ctl.enable ? w_n : win_i;
			since_q    <= ctl.enable ? s_n : since_i;
			tally_q    <= ctl.enable ? t_n : tally_h;
		end
	end

endmodule

// ===== sv/tmpc_motor_lane.sv =====
// ----------------------------------------------------------------------------
// tmpc_motor_lane: one motor's run control
// Stop check, start from its two buttons, run timer and travel budget.
// ----------------------------------------------------------------------------
module tmpc_motor_lane
	import tmpc_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_W_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         limit,     // bit0 top, bit1 bottom
	input  logic               estop,
	input  logic [STEP_W-1:0]  step_nxt,  // step register incl. a write this cycle
	input  btn_evt_t           evt [2],   // [0] up button, [1] down button
	output btn_ctl_t           ctl [2],
	output dir_t               dir_n,
	output logic [PRESS_W-1:0] presses_n
);

	localparam int PROD_W = STEP_W + PRESS_W;
	localparam int CMP_W  = (TIMER_WIDTH > PROD_W) ? TIMER_WIDTH : PROD_W;

	dir_t                   dir_q;
	logic [TIMER_WIDTH-1:0] run_q;
	logic [PRESS_W-1:0]     presses_q;
	logic [PROD_W-1:0]      prod_q;    // step * presses, precomputed

	logic                   running, lim_hit, over, stop;
	logic [TIMER_WIDTH-1:0] run_inc, run_n;
	logic [PRESS_W-1:0]     presses_upd;
	dir_t                   dir_a;

	always_comb begin
		running = (dir_q != DIR_STOP);
		run_inc = (running && run_q != '1) ? run_q + 1'b1 : run_q;
		unique case (dir_q)
			DIR_UP:   lim_hit = limit[0];
			DIR_DOWN: lim_hit = limit[1];
			default:  lim_hit = 1'b0;
		endcase
		over = CMP_W'(run_inc) > CMP_W'(prod_q);
		stop = estop || (running && (lim_hit || over));

		dir_a     = stop ? DIR_STOP : dir_q;
		dir_n     = dir_a;
		run_n     = stop ? '0 : run_inc;
		presses_n = stop ? '0 : presses_q;

		ctl[0].halt   = stop;
		ctl[1].halt   = stop;
		ctl[0].enable = (dir_a == DIR_STOP);

		// up button first; a start there locks out the down button
		if (ctl[0].enable && evt[0].release_hit && evt[0].tally != '0) begin
			presses_n = evt[0].tally;
			if (!limit[0]) begin
				dir_n = DIR_UP;
				run_n = '0;
			end
		end
		ctl[1].enable = (dir_n == DIR_STOP);
		if (ctl[1].enable && evt[1].release_hit && evt[1].tally != '0) begin
			presses_n = evt[1].tally;
			if (!limit[1]) begin
				dir_n = DIR_DOWN;
				run_n = '0;
			end
		end
	end

	assign presses_upd = accept ? presses_n : presses_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q     <= DIR_STOP;
			run_q     <= '0;
			presses_q <= '0;
			prod_q    <= '0;
		end else begin
			if (accept) begin
				dir_q     <= dir_n;
				run_q     <= run_n;
				presses_q <= presses_n;
			end
			prod_q <= PROD_W'(step_nxt) * PROD_W'(presses_upd);
		end
	end

	// a running motor always has a nonzero press count
	a_run_has_presses: assert property (@(posedge clk) disable iff (!arst_n)
		dir_q != DIR_STOP |-> presses_q != '0)
		else $error("motor running with zero press count");

	// nothing can restart a motor in the tick that halted it
	a_halt_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && stop) |=> dir_q == DIR_STOP)
		else $error("motor restarted in the tick it halted");

endmodule

// ===== sv/tmpc_merge.sv =====
// ----------------------------------------------------------------------------
// tmpc_merge: combine lane results into one output beat
// Packs drive bits and press counts; output register plus skid stage.
// ----------------------------------------------------------------------------
module tmpc_merge
	import tmpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  dir_t                  dir1,
	input  dir_t                  dir2,
	input  logic [PRESS_W-1:0]    presses1,
	input  logic [PRESS_W-1:0]    presses2,
	output logic                  in_ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata
);

	logic [3:0]            drive;
	logic [OUT_DATA_W-1:0] beat;
	logic                  out_v_q, skid_v_q;
	logic [OUT_DATA_W-1:0] out_q, skid_q;
	logic                  take;

	always_comb begin
		drive = {dir2 == DIR_DOWN, dir2 == DIR_UP, dir1 == DIR_DOWN, dir1 == DIR_UP};
		beat  = {4'b0, presses2, presses1, drive};
	end

	assign take     = out_v_q && m_tready;
	assign in_ready = !skid_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take || !out_v_q) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= accept;
			end
		end else if (accept) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_v_q) begin
			out_q <= skid_v_q ? skid_q : beat;
		end else if (accept) begin
			skid_q <= beat;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid stage full while output register empty");

	a_stall_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && out_v_q && !m_tready) |=> skid_v_q)
		else $error("beat accepted under stall did not land in skid");

endmodule
